FILE: sv/mpf_pkg.sv
package mpf_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam logic [15:0] END_COUNT    = 16'hFFFF;
  localparam logic [15:0] MIN_TS_LEN   = 16'd11;

  localparam logic [1:0] CFG_REPLAY_MODE      = 2'd0;
  localparam logic [1:0] CFG_DROP_PERIOD      = 2'd1;
  localparam logic [1:0] CFG_DUPLICATE_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_DISCARD = 2'd2
  } record_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MOD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic rem_start;
    logic load_close;
    logic load_end;
    logic load_disc;
    logic add_msg;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic is_end;
    logic skip;
    logic oversize;
    logic open;
    logic need_split;
    logic need_mod;
    logic rem_busy;
    logic out_free;
  } status_t;

endpackage

FILE: sv/mpf_rem.sv
module mpf_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [15:0] rem_o
);
  import mpf_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [63:0] dvd_q, dvd_d;
  logic [16:0] trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[63]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = 16'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[15:0];
      end
      dvd_d = {dvd_q[62:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/mpf_dp.sv
module mpf_dp #(
  parameter int unsigned PACKET_BYTES = 1472
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpf_pkg::cmd_t        cmd_i,
  output mpf_pkg::status_t     status_o,
  input  logic [15:0]          message_length_i,
  input  logic [47:0]          message_time_i,
  input  logic                 stream_end_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           record_kind_o,
  output logic [63:0]          first_sequence_o,
  output logic [15:0]          packet_messages_o,
  output logic [15:0]          packet_payload_bytes_o,
  output logic                 send_it_o,
  output logic                 send_twice_o,
  output logic [47:0]          relative_time_o,
  output logic                 last_record_o
);
  import mpf_pkg::*;

  localparam logic [17:0] PayloadLimit = 18'(PACKET_BYTES - HEADER_BYTES);

  // configuration
  logic        replay_q;
  logic [15:0] drop_q, dupp_q;

  // latched input word
  logic [15:0] len_q;
  logic [47:0] time_q;
  logic        end_q;

  // packet state
  logic [63:0] seq_q;
  logic [15:0] count_q, bytes_q;
  logic [47:0] open_time_q, origin_q;
  logic        origin_seen_q, halted_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [63:0] oseq_q;
  logic [15:0] omsg_q, obytes_q;
  logic        osend_q, otwice_q, olast_q;
  logic [47:0] orel_q;

  logic        busy_drop, busy_dup;
  logic [15:0] rem_drop, rem_dup;
  logic [17:0] word_bytes;
  logic        fits, split_ts, snd, dup;

  mpf_rem u_rem_drop (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (seq_q),
    .divisor_i  (drop_q),
    .busy_o     (busy_drop),
    .rem_o      (rem_drop)
  );

  mpf_rem u_rem_dup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (seq_q),
    .divisor_i  (dupp_q),
    .busy_o     (busy_dup),
    .rem_o      (rem_dup)
  );

  assign word_bytes = {2'b00, len_q} + 18'd2;
  assign fits       = ({2'b00, bytes_q} + word_bytes) <= PayloadLimit;
  assign split_ts   = replay_q && (time_q != open_time_q);

  assign snd = !(!replay_q && (drop_q != 16'd0) && (rem_drop == 16'd0));
  assign dup = snd && !replay_q && (dupp_q != 16'd0) && (rem_dup == 16'd0);

  always_comb begin
    status_o.halted     = halted_q;
    status_o.is_end     = end_q;
    status_o.skip       = replay_q && (len_q < MIN_TS_LEN);
    status_o.oversize   = word_bytes > PayloadLimit;
    status_o.open       = count_q != 16'd0;
    status_o.need_split = (count_q != 16'd0) && (!fits || split_ts);
    status_o.need_mod   = !replay_q && ((drop_q != 16'd0) || (dupp_q != 16'd0));
    status_o.rem_busy   = busy_drop || busy_dup;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replay_q <= 1'b0;
      drop_q   <= '0;
      dupp_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REPLAY_MODE:      replay_q <= cfg_data_i[0];
        CFG_DROP_PERIOD:      drop_q   <= cfg_data_i;
        CFG_DUPLICATE_PERIOD: dupp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      len_q  <= message_length_i;
      time_q <= message_time_i;
      end_q  <= stream_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= 64'd1;
      count_q       <= '0;
      bytes_q       <= '0;
      open_time_q   <= '0;
      origin_q      <= '0;
      origin_seen_q <= 1'b0;
      halted_q      <= 1'b0;
    end else begin
      if (cmd_i.load_close) begin
        seq_q   <= seq_q + {48'd0, count_q};
        count_q <= '0;
        bytes_q <= '0;
      end
      if (cmd_i.load_disc) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.add_msg) begin
        count_q <= count_q + 16'd1;
        bytes_q <= 16'({2'b00, bytes_q} + word_bytes);
        if (count_q == 16'd0) begin
          open_time_q <= time_q;
          if (!origin_seen_q) begin
            origin_q      <= time_q;
            origin_seen_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_close || cmd_i.load_end || cmd_i.load_disc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_close) begin
      kind_q   <= KIND_DATA;
      oseq_q   <= seq_q;
      omsg_q   <= count_q;
      obytes_q <= bytes_q;
      osend_q  <= snd;
      otwice_q <= dup;
      orel_q   <= open_time_q - origin_q;
      olast_q  <= !end_q && !(word_bytes > PayloadLimit);
    end else if (cmd_i.load_end || cmd_i.load_disc) begin
      kind_q   <= cmd_i.load_end ? KIND_END : KIND_DISCARD;
      oseq_q   <= seq_q;
      omsg_q   <= cmd_i.load_end ? END_COUNT : 16'd0;
      obytes_q <= '0;
      osend_q  <= cmd_i.load_end;
      otwice_q <= 1'b0;
      orel_q   <= '0;
      olast_q  <= 1'b1;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign record_kind_o          = kind_q;
  assign first_sequence_o       = oseq_q;
  assign packet_messages_o      = omsg_q;
  assign packet_payload_bytes_o = obytes_q;
  assign send_it_o              = osend_q;
  assign send_twice_o           = otwice_q;
  assign relative_time_o        = orel_q;
  assign last_record_o          = olast_q;

endmodule

FILE: sv/mpf_ctrl.sv
module mpf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mpf_pkg::status_t status_i,
  output mpf_pkg::cmd_t    cmd_o
);
  import mpf_pkg::*;

  state_e state_q, state_d;
  logic   close_now;

  assign close_now = !status_i.halted && status_i.open &&
                     (status_i.is_end ||
                      (!status_i.skip && (status_i.oversize || status_i.need_split)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (status_i.halted) begin
          state_d = ST_IDLE;
        end else if (close_now) begin
          state_d = status_i.need_mod ? ST_MOD : ST_EMIT;
        end else if (status_i.is_end || (!status_i.skip && status_i.oversize)) begin
          if (status_i.out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (!status_i.rem_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_DECIDE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_DECIDE: begin
        priority if (status_i.halted) begin
          cmd_o = '0;
        end else if (close_now) begin
          cmd_o.rem_start = status_i.need_mod;
        end else if (status_i.is_end) begin
          cmd_o.load_end = status_i.out_free;
        end else if (status_i.skip) begin
          cmd_o = '0;
        end else if (status_i.oversize) begin
          cmd_o.load_disc = status_i.out_free;
        end else begin
          cmd_o.add_msg = 1'b1;
        end
      end
      ST_MOD: cmd_o = '0;
      ST_EMIT: begin
        cmd_o.load_close = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/message_packet_framer_top.sv
// channel   direction  handshake               payload
// input     in         in_valid_i/in_ready_o   message_length_i, message_time_i, stream_end_i
// output    out        out_valid_o/out_ready_i record_kind_o .. last_record_o
// config    in         cfg_we_i                cfg_index_i, cfg_data_i
//
// a word that joins the open packet passes through the idle and decide states; a packet
// close adds the emit state, plus the mod state in bulk mode with a nonzero period for the
// bit-serial sequence remainder; a record waits until the output register is free
// asynchronous active-low reset, sequence starts at one, no clearing pass
// a stalled output holds the controller, input ready is low until done
module message_packet_framer_top #(
  parameter int unsigned PACKET_BYTES = 1472
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] message_length_i,
  input  logic [47:0] message_time_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  record_kind_o,
  output logic [63:0] first_sequence_o,
  output logic [15:0] packet_messages_o,
  output logic [15:0] packet_payload_bytes_o,
  output logic        send_it_o,
  output logic        send_twice_o,
  output logic [47:0] relative_time_o,
  output logic        last_record_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mpf_pkg::*;

  cmd_t    cmd;
  status_t status;

  mpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpf_dp #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .message_length_i       (message_length_i),
    .message_time_i         (message_time_i),
    .stream_end_i           (stream_end_i),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .record_kind_o          (record_kind_o),
    .first_sequence_o       (first_sequence_o),
    .packet_messages_o      (packet_messages_o),
    .packet_payload_bytes_o (packet_payload_bytes_o),
    .send_it_o              (send_it_o),
    .send_twice_o           (send_twice_o),
    .relative_time_o        (relative_time_o),
    .last_record_o          (last_record_o)
  );

endmodule
